FILE: hdl/pqps_pkg.sv
// Shared types and operation codes for the process ready queue.
package pqps_pkg;

    typedef enum logic [1:0] {
        OP_PUSH_HEAD = 2'd0,
        OP_PUSH_TAIL = 2'd1,
        OP_POP       = 2'd2,
        OP_SORT      = 2'd3
    } op_t;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] arrival;
        logic [15:0] io;
        logic [15:0] burst;
        logic [7:0]  prio;
    } rec_t;

    typedef struct packed {
        op_t  op;
        rec_t rec;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_KEY,
        ST_RD_PREV,
        ST_CMP,
        ST_DONE
    } st_t;

    // True when record a must come strictly after record b.
    function automatic logic goes_after(rec_t a, rec_t b);
        logic res;
        if (a.prio != b.prio)
        begin
            res = a.prio > b.prio;
        end
        else
        begin
            res = a.arrival > b.arrival;
        end
        return res;
    endfunction

endpackage

FILE: hdl/pqps_front.sv
// Front end: capture items and queue them as commands for the engine.
module pqps_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid,
    output logic            ready,
    input  pqps_pkg::cmd_t  cmd_in,
    output logic            cmd_valid,
    input  logic            cmd_ready,
    output pqps_pkg::cmd_t  cmd_out
);

    pqps_pkg::cmd_t q_reg [2];
    logic           wp_reg, rp_reg;
    logic [1:0]     cnt_reg;

    assign ready     = cnt_reg != 2'd2;
    assign cmd_valid = cnt_reg != 2'd0;
    assign cmd_out   = q_reg[rp_reg];

    // Two-entry command queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (valid && ready)
            begin
                wp_reg <= ~wp_reg;
            end
            if (cmd_valid && cmd_ready)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, valid && ready} - {1'b0, cmd_valid && cmd_ready};
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid && ready)
        begin
            q_reg[wp_reg] <= cmd_in;
        end
    end

endmodule

FILE: hdl/pqps_engine.sv
// Back end: ring store, push and pop, and the insertion sort sequencer.
module pqps_engine #(
    parameter int DEPTH = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  pqps_pkg::cmd_t  cmd,
    output logic            res_valid,
    input  logic            res_ready,
    output logic            res_ok,
    output pqps_pkg::rec_t  res_rec,
    output logic            res_empty,
    output logic            res_drop,
    output logic [8:0]      res_fill
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pqps_pkg::rec_t mem [DEPTH];
    pqps_pkg::rec_t rd_reg, key_reg;
    logic [AW-1:0]  head_reg;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  i_reg, i_next, j_reg, j_next;
    pqps_pkg::st_t  st_reg, st_next;

    logic           wr_en;
    logic [AW-1:0]  wr_addr, rd_addr;
    pqps_pkg::rec_t wr_data;
    logic           res_load;

    // Ring slot of a logical position.
    function automatic logic [AW-1:0] slot(logic [AW-1:0] h, logic [CW-1:0] p);
        logic [CW:0] s;
        s = {1'b0, p} + (CW+1)'(h);
        if (s >= (CW+1)'(DEPTH))
        begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    logic out_free;
    assign out_free  = !res_valid || res_ready;
    assign cmd_ready = (st_reg == pqps_pkg::ST_IDLE) && out_free;

    logic [AW-1:0] head_dec;
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - 1'b1;

    // Sequencer: push/pop complete from the idle state, sort walks the store.
    always_comb
    begin
        st_next  = st_reg;
        i_next   = i_reg;
        j_next   = j_reg;
        wr_en    = 1'b0;
        wr_addr  = head_reg;
        wr_data  = cmd.rec;
        rd_addr  = head_reg;
        res_load = 1'b0;
        case (st_reg)
            pqps_pkg::ST_IDLE:
            begin
                if (cmd_valid && cmd_ready)
                begin
                    case (cmd.op)
                        pqps_pkg::OP_PUSH_HEAD:
                        begin
                            res_load = 1'b1;
                            wr_en    = cnt_reg < CW'(DEPTH);
                            wr_addr  = head_dec;
                        end
                        pqps_pkg::OP_PUSH_TAIL:
                        begin
                            res_load = 1'b1;
                            wr_en    = cnt_reg < CW'(DEPTH);
                            wr_addr  = slot(head_reg, cnt_reg);
                        end
                        pqps_pkg::OP_POP:
                        begin
                            res_load = 1'b1;
                        end
                        default:
                        begin
                            i_next = CW'(1);
                            if (cnt_reg > CW'(1))
                            begin
                                st_next = pqps_pkg::ST_RD_KEY;
                            end
                            else
                            begin
                                st_next = pqps_pkg::ST_DONE;
                            end
                        end
                    endcase
                end
            end
            pqps_pkg::ST_RD_KEY:
            begin
                rd_addr = slot(head_reg, i_reg);
                j_next  = i_reg;
                st_next = pqps_pkg::ST_RD_PREV;
            end
            pqps_pkg::ST_RD_PREV:
            begin
                rd_addr = slot(head_reg, j_reg - 1'b1);
                st_next = pqps_pkg::ST_CMP;
            end
            pqps_pkg::ST_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = slot(head_reg, j_reg);
                if (pqps_pkg::goes_after(rd_reg, key_reg))
                begin
                    wr_data = rd_reg;
                    j_next  = j_reg - 1'b1;
                    if (j_reg == CW'(1))
                    begin
                        st_next = pqps_pkg::ST_CMP;
                    end
                    else
                    begin
                        st_next = pqps_pkg::ST_RD_PREV;
                    end
                end
                else
                begin
                    wr_data = key_reg;
                    i_next  = i_reg + 1'b1;
                    if (i_reg + 1'b1 >= cnt_reg)
                    begin
                        st_next = pqps_pkg::ST_DONE;
                    end
                    else
                    begin
                        st_next = pqps_pkg::ST_RD_KEY;
                    end
                end
                if (j_reg == '0)
                begin
                    wr_data = key_reg;
                    j_next  = j_reg;
                    i_next  = i_reg + 1'b1;
                    if (i_reg + 1'b1 >= cnt_reg)
                    begin
                        st_next = pqps_pkg::ST_DONE;
                    end
                    else
                    begin
                        st_next = pqps_pkg::ST_RD_KEY;
                    end
                end
            end
            pqps_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    res_load = 1'b1;
                    st_next  = pqps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                st_next = pqps_pkg::ST_IDLE;
            end
        endcase
    end

    // Store write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
        if (st_reg == pqps_pkg::ST_RD_KEY)
        begin
            key_reg <= mem[rd_addr];
        end
    end

    // Pointers, count, state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= pqps_pkg::ST_IDLE;
            head_reg  <= '0;
            cnt_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            res_valid <= 1'b0;
            res_ok    <= 1'b0;
            res_drop  <= 1'b0;
            res_empty <= 1'b1;
            res_fill  <= '0;
        end
        else
        begin
            st_reg <= st_next;
            i_reg  <= i_next;
            j_reg  <= j_next;
            if (res_ready)
            begin
                res_valid <= 1'b0;
            end
            if (res_load)
            begin
                res_valid <= 1'b1;
                res_ok    <= 1'b0;
                res_drop  <= 1'b0;
                res_empty <= cnt_reg == '0;
                res_fill  <= 9'(cnt_reg);
                if (st_reg == pqps_pkg::ST_IDLE)
                begin
                    case (cmd.op)
                        pqps_pkg::OP_PUSH_HEAD, pqps_pkg::OP_PUSH_TAIL:
                        begin
                            if (cnt_reg >= CW'(DEPTH))
                            begin
                                res_drop <= 1'b1;
                            end
                            else
                            begin
                                if (cmd.op == pqps_pkg::OP_PUSH_HEAD)
                                begin
                                    head_reg <= head_dec;
                                end
                                cnt_reg   <= cnt_reg + 1'b1;
                                res_empty <= 1'b0;
                                res_fill  <= 9'(cnt_reg + 1'b1);
                            end
                        end
                        pqps_pkg::OP_POP:
                        begin
                            if (cnt_reg != '0)
                            begin
                                res_ok    <= 1'b1;
                                head_reg  <= (head_reg == AW'(DEPTH - 1)) ? '0
                                             : head_reg + 1'b1;
                                cnt_reg   <= cnt_reg - 1'b1;
                                res_empty <= cnt_reg == CW'(1);
                                res_fill  <= 9'(cnt_reg - 1'b1);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
    end

    // Popped record: read comes from the head, gated by a valid pop.
    logic pop_hit_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop_hit_reg <= 1'b0;
        end
        else if (res_load)
        begin
            pop_hit_reg <= 1'b1;
        end
    end

    pqps_pkg::rec_t pop_rec_reg;
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            pop_rec_reg <= mem[head_reg];
        end
    end

    assign res_rec = (res_ok && pop_hit_reg) ? pop_rec_reg : '0;

endmodule

FILE: hdl/process_queue_priority_sort_top.sv
// Top level of the process ready queue with stable priority sort.
// Push and pop results pass the front-end command queue and are registered in the engine.
// Throughput: push and pop sustain one item per cycle while res_ready is held and no sort runs.
// Sort walks the records through ST_RD_KEY, ST_RD_PREV and ST_CMP, then ST_DONE; intake stalled.
// Reset clears the head pointer and count; the store is not cleared.
module process_queue_priority_sort_top #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [15:0] proc_id,
    input  logic [15:0] arrival_time,
    input  logic [15:0] io_time,
    input  logic [15:0] burst_time,
    input  logic [7:0]  prio,
    output logic        res_valid,
    input  logic        res_ready,
    output logic        out_valid,
    output logic [15:0] out_proc_id,
    output logic [15:0] out_arrival,
    output logic [15:0] out_io,
    output logic [15:0] out_burst,
    output logic [7:0]  out_prio,
    output logic        is_empty,
    output logic        dropped,
    output logic [8:0]  fill_count
);

    pqps_pkg::cmd_t cmd_in, cmd;
    logic           cmd_valid, cmd_ready;
    pqps_pkg::rec_t rec;

    assign cmd_in.op  = pqps_pkg::op_t'(op);
    assign cmd_in.rec = '{proc_id, arrival_time, io_time, burst_time, prio};

    pqps_front u_front (
        .clk(clk), .rst_n(rst_n), .valid(in_valid), .ready(in_ready),
        .cmd_in(cmd_in), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_out(cmd)
    );

    pqps_engine #(.DEPTH(DEPTH)) u_engine (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
        .cmd(cmd), .res_valid(res_valid), .res_ready(res_ready), .res_ok(out_valid),
        .res_rec(rec), .res_empty(is_empty), .res_drop(dropped), .res_fill(fill_count)
    );

    assign out_proc_id = rec.id;
    assign out_arrival = rec.arrival;
    assign out_io      = rec.io;
    assign out_burst   = rec.burst;
    assign out_prio    = rec.prio;

endmodule
